>>> design/swer_pkg.sv
// Shared types and constants for the sliding window event rate meter.
package swer_pkg;

  localparam int DEPTH_DEF   = 512;
  localparam int TIME_W      = 32;
  localparam int WINDOW_W    = 20;
  localparam int RATE_W      = 14;
  localparam int EVENTS_W    = 9;
  localparam int OUT_TDATA_W = 24;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = 20'd30000;
  localparam logic [RATE_W-1:0]   RATE_MAX   = 14'd9999;
  localparam logic [EVENTS_W-1:0] COUNT_MAX  = 9'd511;

  // 60000 ms/min * 10 tenths / 5 events per word
  localparam int SCALE   = 120000;
  localparam int SCALE_W = 17;

  typedef enum logic {
    KIND_PUSH  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> design/swer_ring.sv
// Timestamp ring memory: one write port, one registered read port.
module swer_ring #(
  parameter int DEPTH  = swer_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [swer_pkg::TIME_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [swer_pkg::TIME_W-1:0] rdata
);
  import swer_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];
  logic [TIME_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/swer_div.sv
// Restoring divider, one quotient bit per cycle.
module swer_div #(
  parameter int DVD_W = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DVD_W-1:0]              dividend,
  input  logic [swer_pkg::WINDOW_W-1:0] divisor,
  output logic [DVD_W-1:0]              quotient,
  output swer_pkg::div_stat_t           stat
);
  import swer_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_t;

  dstate_t             state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [WINDOW_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0]    quo_r, quo_nxt;
  logic                done_r, done_nxt;

  logic [WINDOW_W:0]   shifted;
  logic [WINDOW_W:0]   diff;
  logic                ge;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          state_nxt = D_RUN;
          cnt_nxt   = CNT_W'(DVD_W);
          rem_nxt   = '0;
          quo_nxt   = dividend;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? diff[WINDOW_W-1:0] : shifted[WINDOW_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = D_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = (state_r == D_RUN);
  assign stat.done = done_r;

endmodule

>>> design/sliding_window_event_rate.sv
// Top level of the sliding window event rate meter.
// Usage:
//   Input stream: in_tuser is the kind (0 = record an event, 1 = query),
//   in_tdata the 32-bit millisecond time. A record writes the time into the
//   ring in the accept cycle and yields no result; when the ring fills, the
//   oldest stamp is dropped, so at most DEPTH-1 stamps are held.
//   A query expires stale stamps oldest first, then returns one result on
//   the output stream: rate in tenths of words per minute (bits 13:0,
//   saturated at 9999) and the stamp count (bits 22:14, saturated at 511).
// Sequence:
//   A record leaves in_tready high.
//   A query passes S_EXP_RD and S_EXP_CHK for each stamp that it checks,
//   as the ring's read port is registered, then S_MUL, the bit-serial
//   divider (S_DIV) and S_OUT. With no stamp left the divider is skipped.
// Reset: ring pointers cleared (ring empty), window set to 30000 ms.
// Stall: the result waits in the output register while out_tready is low;
//   records are still accepted, and a following query runs up to the point
//   where it needs the output register.
// cfg_we writes window_ms (cfg_wdata); the user must do so only while idle, as the block itself leaves this unchecked.
module sliding_window_event_rate #(
  parameter int DEPTH = swer_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [swer_pkg::TIME_W-1:0]      in_tdata,   // [31:0] time_ms
  input  logic                             in_tuser,   // [0] kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [swer_pkg::OUT_TDATA_W-1:0] out_tdata,  // [13:0] rate_tenths,
                                                       // [22:14] events_in_window
  input  logic                             cfg_we,
  input  logic [swer_pkg::WINDOW_W-1:0]    cfg_wdata
);
  import swer_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int PROD_W = PTR_W + SCALE_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP_RD,
    S_EXP_CHK,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    wp_r, wp_nxt;
  logic [PTR_W-1:0]    rp_r, rp_nxt;
  logic [WINDOW_W-1:0] window_r;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [PTR_W-1:0]    count_r, count_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic                div_start_r, div_start_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic              accept;
  logic              push;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  rp_inc;
  logic [PTR_W:0]    count_wrap;
  logic [PTR_W-1:0]  count;
  logic [TIME_W-1:0] ring_rdata;
  logic [TIME_W-1:0] age;
  logic [PROD_W-1:0] quotient;
  div_stat_t         div_stat;
  logic [SCALE_W+PTR_W-1:0] count_ext;
  logic [EVENTS_W-1:0] events_sat;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && (kind_t'(in_tuser) == KIND_PUSH);

  assign wp_inc = (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;

  // stamps held, ring wraps at DEPTH
  assign count_wrap = (wp_r >= rp_r) ? {1'b0, wp_r} - {1'b0, rp_r}
                                     : (PTR_W+1)'(DEPTH) - {1'b0, rp_r} + {1'b0, wp_r};
  assign count      = count_wrap[PTR_W-1:0];

  assign age = now_r - ring_rdata;

  assign count_ext  = (SCALE_W+PTR_W)'(count_r);
  assign events_sat = (count_ext > (SCALE_W+PTR_W)'(COUNT_MAX))
                      ? COUNT_MAX : count_ext[EVENTS_W-1:0];

  swer_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (push),
    .waddr (wp_r),
    .wdata (in_tdata),
    .raddr (rp_r),
    .rdata (ring_rdata)
  );

  swer_div #(
    .DVD_W (PROD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (prod_r),
    .divisor  (window_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    now_nxt       = now_r;
    prod_nxt      = prod_r;
    count_nxt     = count_r;
    rate_nxt      = rate_r;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (push) begin
            wp_nxt = wp_inc;
            // ring full: drop the oldest stamp
            if (wp_inc == rp_r) begin
              rp_nxt = rp_inc;
            end
          end else begin
            now_nxt   = in_tdata;
            state_nxt = S_EXP_RD;
          end
        end
      end
      // read port follows rp_r; its registered data is valid in S_EXP_CHK
      S_EXP_RD: begin
        state_nxt = (rp_r == wp_r) ? S_MUL : S_EXP_CHK;
      end
      S_EXP_CHK: begin
        if (age > TIME_W'(window_r)) begin
          rp_nxt    = rp_inc;
          state_nxt = S_EXP_RD;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        count_nxt = count;
        prod_nxt  = PROD_W'(count) * PROD_W'(SCALE);
        if (count == '0) begin
          rate_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          div_start_nxt = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      // zero window gives an all-ones quotient, which saturates
      S_DIV: begin
        if (div_stat.done) begin
          rate_nxt  = (quotient > PROD_W'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, events_sat, rate_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      window_r    <= WINDOW_RST;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
    end
    now_r      <= now_nxt;
    prod_r     <= prod_nxt;
    count_r    <= count_nxt;
    rate_r     <= rate_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/swer_checker.sv
// Port-level checks for the rate meter, bound to the top level.
module swer_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [swer_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import swer_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // rate never above saturation value
  a_rate_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[RATE_W-1:0] <= RATE_MAX)
    else $error("rate above saturation");

  // empty window reports zero rate
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[RATE_W+EVENTS_W-1:RATE_W] == '0
      |-> out_tdata[RATE_W-1:0] == '0)
    else $error("nonzero rate with no events");

  // a query request takes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("ready during query");

endmodule

bind sliding_window_event_rate swer_checker u_swer_checker (.*);
